FILE: design/btda_pkg.sv
// ----------------------------------------------------------------------------
// btda_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package btda_pkg;

    localparam int VALUE_BITS = 32;

    // decimal digits of the largest value: floor(bits * log10(2)) + 1
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIGIT_W    = 4;

    // binary bits folded into the BCD word per conversion cycle
    localparam int STEP_BITS  = 4;
    localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = STEPS * STEP_BITS;
    localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam int IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W      = $clog2(DIGITS + 1);

    localparam int CHAR_W     = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef t_digit [DIGITS-1:0] t_bcd;

    typedef struct packed {
        t_bcd             bcd;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage

`default_nettype wire

FILE: design/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to its decimal ASCII digits, most
// significant first, leading zeros dropped, last digit flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_valid / i_value / o_stall: a transfer takes place at a
//   rising edge with i_valid high and o_stall low.
//   Output channel o_valid / o_digit_char / o_last_char / i_stall: one
//   character per transfer; o_last_char marks the final digit of a number.
//   Zero gives the single character '0'.
// Timing:
//   The front folds four binary bits per cycle into a BCD word, then hands
//   it to the queue from its done state; it takes no new value while
//   converting, but can load one in the cycle of that hand-over. A
//   two-entry queue feeds the back, which emits one character per cycle
//   through its output register while i_stall is low and the queue holds
//   numbers.
// Reset and stall:
//   Synchronous reset empties the queue and drops any conversion in flight.
//   While i_stall is high the output register holds its character; the
//   queue then fills and the front raises o_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [btda_pkg::VALUE_BITS-1:0] i_value,
    output logic                                 o_stall,
    output logic                                 o_valid,
    output logic [btda_pkg::CHAR_W-1:0]          o_digit_char,
    output logic                                 o_last_char,
    input  wire logic                            i_stall
);
    import btda_pkg::*;

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry pop_entry;

    btda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_value (i_value),
        .o_stall (o_stall),
        .o_push  (push),
        .o_entry (push_entry),
        .i_full  (full)
    );

    btda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (pop_entry),
        .i_pop   (pop)
    );

    btda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_entry    (pop_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_char  (o_last_char),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire

FILE: design/btda_front.sv
// ----------------------------------------------------------------------------
// btda_front
// Accepts a binary value and converts it to BCD with shift-add-3 steps,
// several bits per cycle, then hands digits and digit count to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module btda_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [btda_pkg::VALUE_BITS-1:0] i_value,
    output logic                              o_stall,
    output logic                              o_push,
    output btda_pkg::t_entry                  o_entry,
    input  wire logic                         i_full
);
    import btda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step,  n_step;
    logic [PAD_BITS-1:0] r_bin,   n_bin;
    t_bcd                r_bcd,   n_bcd;
    logic                accept;

    function automatic t_bcd dabble(input t_bcd bcd, input logic bit_in);
        t_bcd                    adj;
        logic [DIGITS*DIGIT_W-1:0] flat;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i] >= 4'd5) begin
                adj[i] = bcd[i] + 4'd3;
            end
        end
        flat = adj;
        return {flat[DIGITS*DIGIT_W-2:0], bit_in};
    endfunction

    function automatic logic [CNT_W-1:0] digit_count(input t_bcd bcd);
        logic [CNT_W-1:0] cnt;
        cnt = CNT_W'(1);
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd[i] != 4'd0) begin
                cnt = CNT_W'(i + 1);
            end
        end
        return cnt;
    endfunction

    assign o_stall = !((r_state == S_IDLE) || ((r_state == S_DONE) && !i_full));
    assign accept  = i_valid && !o_stall;
    assign o_push  = (r_state == S_DONE);

    always_comb begin
        t_bcd                 v_bcd;
        logic [STEP_BITS-1:0] v_chunk;
        n_state = r_state;
        n_step  = r_step;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        v_chunk = r_bin[PAD_BITS-1 -: STEP_BITS];
        v_bcd   = r_bcd;
        for (int j = STEP_BITS - 1; j >= 0; j--) begin
            v_bcd = dabble(v_bcd, v_chunk[j]);
        end
        unique case (r_state)
            S_IDLE: begin
            end
            S_CONV: begin
                n_bcd = v_bcd;
                n_bin = r_bin << STEP_BITS;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // load a new value, also in the cycle the finished one is handed over
        if (accept) begin
            n_state = S_CONV;
            n_step  = '0;
            n_bin   = PAD_BITS'(i_value);
            n_bcd   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_entry.bcd   = r_bcd;
    assign o_entry.count = digit_count(r_bcd);

endmodule

`default_nettype wire

FILE: design/btda_queue.sv
// ----------------------------------------------------------------------------
// btda_queue
// Short FIFO of converted numbers between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module btda_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  btda_pkg::t_entry      i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output btda_pkg::t_entry      o_entry,
    input  wire logic             i_pop
);
    import btda_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, n_wp;
    logic [QPTR_W-1:0]   r_rp, n_rp;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue read while empty");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

FILE: design/btda_back.sv
// ----------------------------------------------------------------------------
// btda_back
// Emits the significant digits of one queued number as ASCII characters,
// most significant first, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btda_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  btda_pkg::t_entry                i_q_entry,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [btda_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                            o_last_char,
    input  wire logic                       i_stall
);
    import btda_pkg::*;

    logic              r_busy,  n_busy;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    t_bcd              r_bcd,   n_bcd;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_char,  n_char;
    logic              r_last,  n_last;
    logic              slot_free;
    logic              emit;
    logic              fin;

    assign slot_free = !r_out_valid || !i_stall;
    assign emit      = r_busy && slot_free;
    assign fin       = emit && (r_idx == '0);
    assign o_pop     = i_q_valid && (!r_busy || fin);

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_bcd       = r_bcd;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_char      = ASCII_ZERO + CHAR_W'(r_bcd[r_idx]);
            n_last      = (r_idx == '0);
            if (r_idx == '0) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx - 1'b1;
            end
        end else if (slot_free) begin
            n_out_valid = 1'b0;
        end
        // start at the leading significant digit
        if (o_pop) begin
            n_busy = 1'b1;
            n_bcd  = i_q_entry.bcd;
            n_idx  = IDX_W'(i_q_entry.count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_char  = r_last;

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= 6'd48 && o_digit_char <= 6'd57))
        else $error("output character is not a decimal digit");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_char) |=> o_valid)
        else $error("digit run broken before its last character");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_busy) |-> (r_idx == '0 && emit))
        else $error("new number taken while digits remain");

endmodule

`default_nettype wire
